[design/ric_pkg.sv]
// Shared types and constants for the reference-counted inode cache.
// Holds the beat codes, the token that walks the cell chain and the commit bundle.
// No dependencies.
package ric_pkg;

   localparam int SLOT_W        = 6;
   localparam int DEVICE_W      = 8;
   localparam int INODE_W       = 32;
   localparam int COUNT_W       = 16;
   localparam int OFFSET_W      = 3;
   localparam int SLOT_LIMIT    = 2 ** SLOT_W;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   typedef enum logic [2:0] {
      STATUS_HIT      = 3'd0,
      STATUS_ALLOC    = 3'd1,
      STATUS_FULL     = 3'd2,
      STATUS_HELD     = 3'd3,
      STATUS_RELEASED = 3'd4,
      STATUS_NULL     = 3'd5
   } status_type;

   // Request token handed from cell to cell, gathering the scan outcome.
   typedef struct packed {
      logic                valid;
      logic                op;
      logic [DEVICE_W-1:0] device;
      logic [INODE_W-1:0]  inode;
      logic [SLOT_W-1:0]   slot;
      logic                is_null;
      logic                hit_found;
      logic [SLOT_W-1:0]   hit_slot;
      logic                free_found;
      logic [SLOT_W-1:0]   free_slot;
      logic                put_held;
   } token_type;

   // Update broadcast to all cells once a get has passed the whole chain.
   typedef struct packed {
      logic                valid;
      logic                alloc;
      logic [DEVICE_W-1:0] device;
      logic [INODE_W-1:0]  inode;
   } commit_type;

endpackage

[design/ric_cell.sv]
// One inode slot of the cache chain: count, device and inode of the slot.
// Marks itself as the hit or free candidate as the token passes by.
// Depends on ric_pkg.
module ric_cell #(
   parameter int INDEX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  ric_pkg::token_type  tok_i,
   input  ric_pkg::commit_type commit_i,
   output ric_pkg::token_type  tok_o
);

   logic [ric_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [ric_pkg::DEVICE_W-1:0] dev_ff, dev_in;
   logic [ric_pkg::INODE_W-1:0]  ino_ff, ino_in;
   logic                         hit_mark_ff, hit_mark_in;
   logic                         free_mark_ff, free_mark_in;
   ric_pkg::token_type           tok_ff, tok_in;
   logic                         in_use;
   logic                         match;
   logic                         put_here;

   always_comb begin
      count_in     = count_ff;
      dev_in       = dev_ff;
      ino_in       = ino_ff;
      hit_mark_in  = hit_mark_ff;
      free_mark_in = free_mark_ff;
      tok_in       = tok_i;

      in_use   = count_ff != '0;
      match    = in_use && (dev_ff == tok_i.device) && (ino_ff == tok_i.inode);
      put_here = (INDEX < ric_pkg::SLOT_LIMIT) && !tok_i.is_null &&
                 (ric_pkg::SLOT_W'(INDEX) == tok_i.slot);

      if (tok_i.valid) begin
         if (tok_i.op == ric_pkg::OP_GET) begin
            hit_mark_in  = match && !tok_i.hit_found;
            free_mark_in = !in_use && !tok_i.free_found;
            if (hit_mark_in) begin
               tok_in.hit_found = 1'b1;
               tok_in.hit_slot  = ric_pkg::SLOT_W'(INDEX);
            end
            if (free_mark_in) begin
               tok_in.free_found = 1'b1;
               tok_in.free_slot  = ric_pkg::SLOT_W'(INDEX);
            end
         end else if (put_here) begin
            if (in_use) begin
               count_in = count_ff - 1'b1;
            end
            tok_in.put_held = count_ff > ric_pkg::COUNT_W'(1);
         end
      end

      // Marks were left by the last get, which has just reached the end of the chain.
      if (commit_i.valid) begin
         if (commit_i.alloc && free_mark_ff) begin
            count_in = ric_pkg::COUNT_W'(1);
            dev_in   = commit_i.device;
            ino_in   = commit_i.inode;
         end else if (!commit_i.alloc && hit_mark_ff && count_ff != ric_pkg::COUNT_MAX) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         tok_ff   <= '0;
      end else begin
         count_ff <= count_in;
         tok_ff   <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      dev_ff       <= dev_in;
      ino_ff       <= ino_in;
      hit_mark_ff  <= hit_mark_in;
      free_mark_ff <= free_mark_in;
   end

   assign tok_o = tok_ff;

endmodule

[design/refcounted_inode_cache_core.sv]
// Top level of the reference-counted inode cache: a chain of slot cells,
// the configuration register and the response register.
// Depends on ric_pkg and ric_cell.
//
// Usage:
//   A request beat is taken at a clock edge where start is high and busy is low.
//   op selects get or put; device and inode_number serve a get, slot_index and
//   slot_is_null a put. The request walks the slot cells one per cycle, passing
//   the register of each cell and then the response register. busy stays high
//   from acceptance until the response is registered, and is low as it is shown,
//   so the block takes a new beat only once it is through with the last one.
//   The response beat is shown for a single cycle with rsp_strobe high and
//   must be taken then; there is no back-pressure on it.
//   Count updates for a get are applied at the edge that registers the response.
//   csr_inode_table_base is written whenever csr_valid is high (csr_ready is
//   always high) and should only change while the block is idle.
//   Reset clears every reference count, so all slots start free, and sets the
//   table base to zero; no response is pending after reset.
module refcounted_inode_cache_core #(
   parameter int SLOT_COUNT = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_op,
   input  logic [7:0]  req_device,
   input  logic [31:0] req_inode_number,
   input  logic [5:0]  req_slot_index,
   input  logic        req_slot_is_null,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [5:0]  rsp_result_slot,
   output logic [31:0] rsp_fetch_block,
   output logic [2:0]  rsp_fetch_offset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_inode_table_base
);

   ric_pkg::token_type  chain [SLOT_COUNT+1];
   ric_pkg::token_type  last;
   ric_pkg::commit_type commit;
   logic                accept;
   logic                busy_ff, busy_in;
   logic [31:0]         base_ff, base_in;
   logic                strobe_ff, strobe_in;
   ric_pkg::status_type status_ff, status_in;
   logic [5:0]          slot_ff, slot_in;
   logic [31:0]         block_ff, block_in;
   logic [2:0]          offset_ff, offset_in;
   logic [31:0]         ino_m1;

   assign accept    = start && !busy_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      chain[0]            = '0;
      chain[0].valid      = accept;
      chain[0].op         = req_op;
      chain[0].device     = req_device;
      chain[0].inode      = req_inode_number;
      chain[0].slot       = req_slot_index;
      chain[0].is_null    = req_slot_is_null;
   end

   for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
      ric_cell #(
         .INDEX (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .tok_i    (chain[i]),
         .commit_i (commit),
         .tok_o    (chain[i+1])
      );
   end

   assign last = chain[SLOT_COUNT];

   always_comb begin
      commit.valid  = last.valid && (last.op == ric_pkg::OP_GET) &&
                      (last.hit_found || last.free_found);
      commit.alloc  = !last.hit_found;
      commit.device = last.device;
      commit.inode  = last.inode;
   end

   always_comb begin
      busy_in   = busy_ff;
      base_in   = base_ff;
      strobe_in = last.valid;
      status_in = status_ff;
      slot_in   = slot_ff;
      block_in  = block_ff;
      offset_in = offset_ff;
      ino_m1    = last.inode - 32'd1;

      if (accept) begin
         busy_in = 1'b1;
      end else if (last.valid) begin
         busy_in = 1'b0;
      end

      if (csr_valid) begin
         base_in = csr_inode_table_base;
      end

      if (last.valid) begin
         slot_in   = '0;
         block_in  = '0;
         offset_in = '0;
         if (last.op == ric_pkg::OP_GET) begin
            if (last.hit_found) begin
               status_in = ric_pkg::STATUS_HIT;
               slot_in   = last.hit_slot;
            end else if (last.free_found) begin
               status_in = ric_pkg::STATUS_ALLOC;
               slot_in   = last.free_slot;
               block_in  = (ino_m1 >> ric_pkg::OFFSET_W) + base_ff;
               offset_in = ino_m1[ric_pkg::OFFSET_W-1:0];
            end else begin
               status_in = ric_pkg::STATUS_FULL;
            end
         end else if (last.is_null || int'(last.slot) >= SLOT_COUNT) begin
            status_in = ric_pkg::STATUS_NULL;
         end else begin
            status_in = last.put_held ? ric_pkg::STATUS_HELD : ric_pkg::STATUS_RELEASED;
            slot_in   = last.slot;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         base_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         base_ff   <= base_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      slot_ff   <= slot_in;
      block_ff  <= block_in;
      offset_ff <= offset_in;
   end

   assign busy             = busy_ff;
   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = status_ff;
   assign rsp_result_slot  = slot_ff;
   assign rsp_fetch_block  = block_ff;
   assign rsp_fetch_offset = offset_ff;

endmodule

[dv/testbench.sv]
// Self-checking testbench for refcounted_inode_cache_core: a queue-fed driver and
// a monitor that predicts every response from its own copy of the slot table.
// Depends on ric_pkg and the RTL of refcounted_inode_cache_core.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS            = 64;
   localparam int CLOCK_PERIOD     = 10;
   localparam int RESET_CYCLES     = 4;
   localparam int INODES_PER_BLOCK = 8;
   localparam int TARGET_BEATS     = 920;
   localparam int FILL_BEATS       = 140;
   localparam int CALM_TAIL        = 100;
   localparam int SETTLE_CYCLES    = 4;
   localparam int DRAIN_CYCLES     = SLOTS + 8;
   localparam int CYCLE_LIMIT      = 600000;
   localparam int PRINT_LIMIT      = 40;

   typedef struct {
      logic                         is_cfg;
      logic [ric_pkg::INODE_W-1:0]  cfg_value;
      logic                         op;
      logic [ric_pkg::DEVICE_W-1:0] device;
      logic [ric_pkg::INODE_W-1:0]  inode;
      logic [ric_pkg::SLOT_W-1:0]   slot;
      logic                         is_null;
   } cache_beat_type;

   typedef struct {
      ric_pkg::status_type          status;
      logic [ric_pkg::SLOT_W-1:0]   slot;
      logic [ric_pkg::INODE_W-1:0]  block;
      logic [ric_pkg::OFFSET_W-1:0] offset;
   } cache_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_op = ric_pkg::OP_GET;
   logic [7:0]          req_device = '0;
   logic [31:0]         req_inode_number = '0;
   logic [5:0]          req_slot_index = '0;
   logic                req_slot_is_null = 1'b0;
   logic                rsp_strobe;
   logic [2:0]          rsp_status;
   logic [5:0]          rsp_result_slot;
   logic [31:0]         rsp_fetch_block;
   logic [2:0]          rsp_fetch_offset;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [31:0]         csr_inode_table_base = '0;

   cache_beat_type      request_plan[$];
   cache_result_type    awaited_results[$];

   // Shadow copy of the slot table and the table base.
   logic [ric_pkg::COUNT_W-1:0]  slot_refs [SLOTS];
   logic [ric_pkg::DEVICE_W-1:0] slot_dev [SLOTS];
   logic [ric_pkg::INODE_W-1:0]  slot_ino [SLOTS];
   logic [ric_pkg::INODE_W-1:0]  table_base = '0;

   int                  mismatch_count = 0;
   int                  cycle_count = 0;
   int                  beats_queued = 0;
   int                  idle_left = 0;
   int                  settle_cycles = 0;
   logic                req_taken = 1'b0;
   logic                csr_taken = 1'b0;

   refcounted_inode_cache_core #(.SLOT_COUNT(SLOTS)) DUT (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_op              (req_op),
      .req_device          (req_device),
      .req_inode_number    (req_inode_number),
      .req_slot_index      (req_slot_index),
      .req_slot_is_null    (req_slot_is_null),
      .rsp_strobe          (rsp_strobe),
      .rsp_status          (rsp_status),
      .rsp_result_slot     (rsp_result_slot),
      .rsp_fetch_block     (rsp_fetch_block),
      .rsp_fetch_offset    (rsp_fetch_offset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_inode_table_base(csr_inode_table_base)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   initial begin
      for (int k = 0; k < SLOTS; k++) begin
         slot_refs[k] = '0;
         slot_dev[k]  = '0;
         slot_ino[k]  = '0;
      end
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, what);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
   endtask

   // Applies one request beat to the shadow table and returns the response it earns.
   function automatic cache_result_type lookup_or_release(input logic op,
         input logic [ric_pkg::DEVICE_W-1:0] device, input logic [ric_pkg::INODE_W-1:0] inode,
         input logic [ric_pkg::SLOT_W-1:0] slot, input logic is_null);
      cache_result_type r;
      int hit_at;
      int free_at;
      logic [ric_pkg::INODE_W-1:0] rel;
      r.status = ric_pkg::STATUS_NULL;
      r.slot   = '0;
      r.block  = '0;
      r.offset = '0;
      hit_at   = -1;
      free_at  = -1;
      if (op == ric_pkg::OP_GET) begin
         for (int k = 0; k < SLOTS; k++) begin
            if (hit_at < 0 && slot_refs[k] != 0 && slot_dev[k] == device
                && slot_ino[k] == inode) hit_at = k;
            if (free_at < 0 && slot_refs[k] == 0) free_at = k;
         end
         if (hit_at >= 0) begin
            if (slot_refs[hit_at] != ric_pkg::COUNT_MAX) slot_refs[hit_at]++;
            r.status = ric_pkg::STATUS_HIT;
            r.slot   = ric_pkg::SLOT_W'(hit_at);
         end else if (free_at >= 0) begin
            slot_refs[free_at] = ric_pkg::COUNT_W'(1);
            slot_dev[free_at]  = device;
            slot_ino[free_at]  = inode;
            // Inode numbers count from one, so zero wraps to the last offset.
            rel      = inode - 32'd1;
            r.status = ric_pkg::STATUS_ALLOC;
            r.slot   = ric_pkg::SLOT_W'(free_at);
            r.block  = rel / INODES_PER_BLOCK + table_base;
            r.offset = ric_pkg::OFFSET_W'(rel % INODES_PER_BLOCK);
         end else begin
            r.status = ric_pkg::STATUS_FULL;
         end
      end else if (!is_null && slot < SLOTS) begin
         if (slot_refs[slot] != 0) slot_refs[slot]--;
         r.status = (slot_refs[slot] != 0) ? ric_pkg::STATUS_HELD : ric_pkg::STATUS_RELEASED;
         r.slot   = slot;
      end
      return r;
   endfunction

   task automatic queue_get(input logic [ric_pkg::DEVICE_W-1:0] device,
                            input logic [ric_pkg::INODE_W-1:0] inode);
      cache_beat_type b;
      b.is_cfg    = 1'b0;
      b.cfg_value = '0;
      b.op        = ric_pkg::OP_GET;
      b.device    = device;
      b.inode     = inode;
      b.slot      = ric_pkg::SLOT_W'($urandom);
      b.is_null   = 1'($urandom);
      request_plan.push_back(b);
      beats_queued++;
   endtask

   task automatic queue_put(input logic [ric_pkg::SLOT_W-1:0] slot, input logic is_null);
      cache_beat_type b;
      b.is_cfg    = 1'b0;
      b.cfg_value = '0;
      b.op        = ric_pkg::OP_PUT;
      b.device    = ric_pkg::DEVICE_W'($urandom);
      b.inode     = $urandom;
      b.slot      = slot;
      b.is_null   = is_null;
      request_plan.push_back(b);
      beats_queued++;
   endtask

   task automatic queue_base(input logic [ric_pkg::INODE_W-1:0] value);
      cache_beat_type b;
      b.is_cfg    = 1'b1;
      b.cfg_value = value;
      b.op        = ric_pkg::OP_GET;
      b.device    = '0;
      b.inode     = '0;
      b.slot      = '0;
      b.is_null   = 1'b0;
      request_plan.push_back(b);
   endtask

   // Claims every slot, asks a few more times while full, then drops one reference per slot.
   task automatic queue_fill_and_drain(input logic [ric_pkg::DEVICE_W-1:0] device,
                                       input logic [ric_pkg::INODE_W-1:0] hot_inode);
      logic [ric_pkg::INODE_W-1:0] stem;
      stem = $urandom & 32'hFFFF_FF00;
      for (int k = 0; k < SLOTS + 6; k++) queue_get(device, stem | k);
      queue_get(ric_pkg::DEVICE_W'($urandom), $urandom);
      queue_get(device, stem);
      queue_get(device, hot_inode);
      for (int k = 0; k < SLOTS; k++) queue_put(ric_pkg::SLOT_W'(k), 1'b0);
   endtask

   // Request driver: a beat is held on the ports until the block takes it.
   always @(negedge clock) begin : drive_beats
      logic next_start;
      logic next_csr;
      cache_beat_type beat;
      next_start = start;
      next_csr   = csr_valid;
      if (!reset) begin
         if (start && req_taken) next_start = 1'b0;
         if (csr_valid && csr_taken) next_csr = 1'b0;
         if (!next_start && !next_csr && request_plan.size() != 0) begin
            if (idle_left != 0) begin
               // A gap only counts down once the block could take a beat.
               if (!busy) idle_left--;
            end else if (request_plan[0].is_cfg) begin
               // The table base moves only once every outstanding response is home.
               if (awaited_results.size() == 0 && !busy && !start) settle_cycles++;
               else settle_cycles = 0;
               if (settle_cycles >= SETTLE_CYCLES) begin
                  beat = request_plan.pop_front();
                  csr_inode_table_base <= beat.cfg_value;
                  next_csr      = 1'b1;
                  settle_cycles = 0;
               end
            end else begin
               beat = request_plan.pop_front();
               req_op           <= beat.op;
               req_device       <= beat.device;
               req_inode_number <= beat.inode;
               req_slot_index   <= beat.slot;
               req_slot_is_null <= beat.is_null;
               next_start = 1'b1;
               if (request_plan.size() > CALM_TAIL && $urandom_range(0, 2) == 0)
                  idle_left = $urandom_range(1, 14);
            end
         end
      end
      start     <= next_start;
      csr_valid <= next_csr;
   end

   // Monitor: checks responses, predicts accepted beats and tracks base writes.
   always @(posedge clock) begin : watch_ports
      cache_result_type want;
      req_taken = 1'b0;
      csr_taken = 1'b0;
      if (!reset) begin
         cycle_count++;
         if (rsp_strobe) begin
            if (awaited_results.size() == 0) begin
               report_mismatch($sformatf("response beat with nothing outstanding, status %0d",
                                         rsp_status));
            end else begin
               want = awaited_results.pop_front();
               check_field("status", rsp_status, want.status);
               check_field("result_slot", rsp_result_slot, want.slot);
               check_field("fetch_block", rsp_fetch_block, want.block);
               check_field("fetch_offset", rsp_fetch_offset, want.offset);
            end
         end
         if (start && !busy) begin
            awaited_results.push_back(lookup_or_release(req_op, req_device, req_inode_number,
                                                        req_slot_index, req_slot_is_null));
            req_taken = 1'b1;
         end
         if (csr_valid && csr_ready) begin
            table_base = csr_inode_table_base;
            csr_taken  = 1'b1;
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("FAIL refcounted_inode_cache_core");
      $finish;
   end

   initial begin : stimulus
      logic [ric_pkg::DEVICE_W-1:0] pool_dev [8];
      logic [ric_pkg::INODE_W-1:0]  pool_ino [8];
      int kind;
      int run_len;
      int fills_done;
      int pick;
      logic [ric_pkg::INODE_W-1:0] base_choice;
      fills_done = 0;

      // Directed opening: edges of the fields, hits, releases and wrap-around.
      queue_base(32'h0000_1000);
      queue_get(8'h00, 32'd1);
      queue_get(8'hFF, 32'hFFFF_FFFF);
      queue_get(8'h00, 32'd1);
      queue_get(8'h01, 32'd1);
      queue_get(8'h00, 32'd0);
      queue_put(6'd0, 1'b0);
      queue_put(6'd0, 1'b0);
      queue_put(6'd0, 1'b0);
      queue_put(6'd5, 1'b1);
      queue_put(6'd63, 1'b0);
      queue_get(8'h00, 32'd9);
      queue_get(8'hFF, 32'hFFFF_FFFF);
      queue_put(6'd1, 1'b0);
      queue_put(6'd1, 1'b0);
      queue_base(32'hFFFF_FFFF);
      queue_get(8'h07, 32'd17);
      queue_get(8'h07, 32'd0);
      queue_get(8'hA5, 32'hFFFF_FFF8);
      queue_base(32'h0000_0000);
      for (int s = 0; s < 6; s++) queue_put(ric_pkg::SLOT_W'(s), 1'b0);

      for (int k = 0; k < 8; k++) begin
         pool_dev[k] = ric_pkg::DEVICE_W'($urandom);
         pool_ino[k] = $urandom;
      end

      while (beats_queued < TARGET_BEATS) begin
         kind = $urandom_range(0, 19);
         if (fills_done == 0 && beats_queued > 350) kind = 19;
         if (kind <= 12) begin
            // Well-formed traffic: a small working set so that gets hit and puts land.
            pick = $urandom_range(0, 7);
            pool_dev[pick] = ric_pkg::DEVICE_W'($urandom);
            pool_ino[pick] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : $urandom;
            run_len = $urandom_range(4, 16);
            for (int n = 0; n < run_len; n++) begin
               pick = $urandom_range(0, 7);
               if ($urandom_range(0, 9) < 6) queue_get(pool_dev[pick], pool_ino[pick]);
               else queue_put(ric_pkg::SLOT_W'($urandom_range(0, 23)), 1'b0);
            end
         end else if (kind <= 15) begin
            if ($urandom_range(0, 1) == 0) queue_get(ric_pkg::DEVICE_W'($urandom), $urandom);
            else queue_put(ric_pkg::SLOT_W'($urandom), 1'($urandom));
         end else if (kind == 16) begin
            queue_put(ric_pkg::SLOT_W'($urandom), 1'b1);
         end else if (kind <= 18) begin
            case ($urandom_range(0, 3))
               0: base_choice = 32'h0000_0000;
               1: base_choice = 32'hFFFF_FFFF;
               2: base_choice = 32'h8000_0000;
               default: base_choice = $urandom;
            endcase
            queue_base(base_choice);
         end else if (fills_done < 2 && beats_queued + FILL_BEATS < TARGET_BEATS) begin
            queue_fill_and_drain(ric_pkg::DEVICE_W'($urandom), pool_ino[0]);
            fills_done++;
         end
      end

      wait (!reset);
      do begin
         @(posedge clock);
         #1;
      end while (request_plan.size() != 0 || start || csr_valid
                 || awaited_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && awaited_results.size() == 0) begin
         $display("PASS refcounted_inode_cache_core");
      end else begin
         $display("FAIL refcounted_inode_cache_core");
      end
      $finish;
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

endmodule
